FILE: rtl/core/scrp_pkg.sv
// Package for the serial-commanded RGB PWM lamp.
// Holds item codes, character constants, the shared structs and hex helpers.
// No dependencies.
package scrp_pkg;

  localparam int LineDepthDef = 32;

  // Item kinds carried on the command field.
  localparam logic CmdByte = 1'b0;
  localparam logic CmdTick = 1'b1;

  // Characters that steer the line parser.
  localparam logic [7:0] CharPct    = 8'h25;  // '%'
  localparam logic [7:0] CharDollar = 8'h24;  // '$'
  localparam logic [7:0] CharHash   = 8'h23;  // '#'

  localparam int MinCmdLen = 4;
  localparam int ColourLen = 7;
  localparam int HistDepth = 7;

  // Reset levels of the lamp.
  localparam logic [7:0] RedReset   = 8'd255;
  localparam logic [7:0] GreenReset = 8'd0;
  localparam logic [7:0] BlueReset  = 8'd128;

  // One advancing item as seen by the processing units.
  typedef struct packed {
    logic       byte_ev;
    logic       tick_ev;
    logic [7:0] data;
  } scrp_ev_t;

  // Lamp settings held by the line parser.
  typedef struct packed {
    logic       lamp_en;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } scrp_lvl_t;

  // Output pin levels.
  typedef struct packed {
    logic activity;
    logic heartbeat;
    logic lamp;
    logic blue;
    logic green;
    logic red;
  } scrp_pins_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } scrp_nib_t;

  function automatic scrp_nib_t hex_nib(input logic [7:0] c);
    scrp_nib_t n;
    n.ok  = 1'b1;
    n.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      n.val = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      n.val = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      n.val = 4'(c - 8'h37);
    end else begin
      n.ok = 1'b0;
    end
    return n;
  endfunction

  // Leading hex digits of a two-character pair.
  function automatic logic [7:0] hex_pair(input logic [7:0] hi_c, input logic [7:0] lo_c);
    scrp_nib_t hi;
    scrp_nib_t lo;
    logic [7:0] r;
    hi = hex_nib(hi_c);
    lo = hex_nib(lo_c);
    if (!hi.ok) begin
      r = 8'd0;
    end else if (!lo.ok) begin
      r = {4'd0, hi.val};
    end else begin
      r = {hi.val, lo.val};
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/scrp_line_parser.sv
// Line parser: tracks the line index and the recent bytes of the line,
// decodes finished lines into lamp on/off and colour levels. Uses scrp_pkg.
module scrp_line_parser #(
  parameter int LINE_DEPTH = scrp_pkg::LineDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  scrp_pkg::scrp_ev_t  ev_i,
  output scrp_pkg::scrp_lvl_t lvl_o
);
  import scrp_pkg::*;

  localparam int IdxW = $clog2(LINE_DEPTH);

  logic [IdxW-1:0] idx_q, idx_d;
  logic [7:0]      hist_q [HistDepth];
  scrp_lvl_t       lvl_q, lvl_d;
  logic            tail_pct, tail_dollar;

  // hist_q[0] is the most recent byte of the line.
  assign tail_pct    = (hist_q[0] == CharPct) && (hist_q[1] == CharPct) &&
                       (hist_q[2] == CharPct);
  assign tail_dollar = (hist_q[0] == CharDollar) && (hist_q[1] == CharDollar) &&
                       (hist_q[2] == CharDollar);

  always_comb begin
    idx_d = idx_q;
    lvl_d = lvl_q;
    if (ev_i.byte_ev) begin
      if (ev_i.data == CharHash) begin
        idx_d = '0;
        // A short line is ignored.
        if (idx_q >= IdxW'(MinCmdLen)) begin
          if (tail_pct) begin
            lvl_d.lamp_en = 1'b0;
          end else if (tail_dollar) begin
            lvl_d.lamp_en = 1'b1;
          end else if (hist_q[6] == CharDollar && idx_q == IdxW'(ColourLen)) begin
            lvl_d.red   = hex_pair(hist_q[5], hist_q[4]);
            lvl_d.green = hex_pair(hist_q[3], hist_q[2]);
            lvl_d.blue  = hex_pair(hist_q[1], hist_q[0]);
          end
        end
      end else if (idx_q == IdxW'(LINE_DEPTH - 1)) begin
        idx_d = '0;
      end else begin
        idx_d = idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q         <= '0;
      lvl_q.lamp_en <= 1'b1;
      lvl_q.red     <= RedReset;
      lvl_q.green   <= GreenReset;
      lvl_q.blue    <= BlueReset;
    end else begin
      idx_q <= idx_d;
      lvl_q <= lvl_d;
    end
  end

  // Shift in every byte except the line terminator.
  always_ff @(posedge clk_i) begin
    if (ev_i.byte_ev && ev_i.data != CharHash) begin
      hist_q[0] <= ev_i.data;
      for (int i = 1; i < HistDepth; i++) begin
        hist_q[i] <= hist_q[i-1];
      end
    end
  end

  assign lvl_o = lvl_q;

endmodule

FILE: rtl/core/scrp_pwm.sv
// PWM unit: 8-bit period counter, heartbeat, lamp switch and colour
// comparators, plus the activity toggle. Uses scrp_pkg.
module scrp_pwm (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  scrp_pkg::scrp_ev_t   ev_i,
  input  scrp_pkg::scrp_lvl_t  lvl_i,
  output scrp_pkg::scrp_pins_t pins_o
);
  import scrp_pkg::*;

  logic [7:0] cnt_q, cnt_d;
  scrp_pins_t pins_q, pins_d;

  always_comb begin
    cnt_d  = cnt_q;
    pins_d = pins_q;
    if (ev_i.tick_ev) begin
      cnt_d = cnt_q + 8'd1;
      if (cnt_d == 8'd0) begin
        pins_d.heartbeat = ~pins_q.heartbeat;
      end
      pins_d.lamp  = lvl_i.lamp_en;
      pins_d.red   = (cnt_d < lvl_i.red);
      pins_d.green = (cnt_d < lvl_i.green);
      pins_d.blue  = (cnt_d < lvl_i.blue);
    end
    if (ev_i.byte_ev) begin
      pins_d.activity = ~pins_q.activity;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      pins_q <= '0;
    end else begin
      cnt_q  <= cnt_d;
      pins_q <= pins_d;
    end
  end

  assign pins_o = pins_q;

endmodule

FILE: rtl/core/serial_commanded_rgb_pwm.sv
// An accepted item passes the input register, then the result register,
// on its way to the ports; one item per cycle unless the input is stalled.
// Backpressure from the result side stalls the input only when both the
// input register and the result register are full.
// Reset (rst_ni, async, active low) clears the line index, the PWM counter
// and all pins; levels return to red 255, green 0, blue 128, lamp enabled.
module serial_commanded_rgb_pwm #(
  parameter int LINE_DEPTH = scrp_pkg::LineDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       command_i,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       echo_valid_o,
  output logic [7:0] echo_byte_o,
  output logic       red_pin_o,
  output logic       green_pin_o,
  output logic       blue_pin_o,
  output logic       lamp_switch_o,
  output logic       heartbeat_pin_o,
  output logic       activity_pin_o
);
  import scrp_pkg::*;

  // Input register: holds one accepted item until the result side has room.
  logic       in_valid_q;
  logic       in_cmd_q;
  logic [7:0] in_byte_q;

  // Result register: echo part of the result. The pin part lives in the PWM
  // unit, whose registers only move when a new result is loaded here.
  logic       out_valid_q;
  logic       echo_valid_q;
  logic [7:0] echo_byte_q;

  logic       out_ready;
  logic       adv;
  scrp_ev_t   ev;
  scrp_lvl_t  lvl;
  scrp_pins_t pins;

  // The result slot is free when empty or when its item is being taken.
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign adv        = in_valid_q && out_ready;
  assign in_stall_o = in_valid_q && !out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // Capture the item payload on acceptance.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_cmd_q  <= command_i;
      in_byte_q <= rx_byte_i;
    end
  end

  // Item moving from the input register into processing this cycle.
  assign ev.byte_ev = adv && (in_cmd_q == CmdByte);
  assign ev.tick_ev = adv && (in_cmd_q == CmdTick);
  assign ev.data    = in_byte_q;

  scrp_line_parser #(
    .LINE_DEPTH(LINE_DEPTH)
  ) u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ev_i   (ev),
    .lvl_o  (lvl)
  );

  scrp_pwm u_pwm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ev_i   (ev),
    .lvl_i  (lvl),
    .pins_o (pins)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= adv;
    end
  end

  // Echo the byte on byte items; ticks carry a zero echo.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      echo_valid_q <= ev.byte_ev;
      echo_byte_q  <= ev.byte_ev ? in_byte_q : 8'd0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign echo_valid_o    = echo_valid_q;
  assign echo_byte_o     = echo_byte_q;
  assign red_pin_o       = pins.red;
  assign green_pin_o     = pins.green;
  assign blue_pin_o      = pins.blue;
  assign lamp_switch_o   = pins.lamp;
  assign heartbeat_pin_o = pins.heartbeat;
  assign activity_pin_o  = pins.activity;

endmodule

FILE: rtl/core/scrp_checker.sv
// Port-level checks for serial_commanded_rgb_pwm and the bind that attaches
// them. Depends only on the top level's ports.
module scrp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       echo_valid_o,
  input logic [7:0] echo_byte_o,
  input logic       red_pin_o,
  input logic       activity_pin_o
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(echo_byte_o))
    else $error("stalled result changed");

  // Input stalls only when the result side is full and stalled.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  // Activity pin moves only with a newly shown byte result.
  a_act_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(activity_pin_o) |-> out_valid_o && echo_valid_o)
    else $error("activity pin moved without a byte result");

  // Colour pins move only with a tick result.
  a_red_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(red_pin_o) |-> out_valid_o && !echo_valid_o)
    else $error("red pin moved without a tick result");

  // Tick results carry a zero echo byte.
  a_tick_echo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !echo_valid_o |-> echo_byte_o == 8'd0)
    else $error("tick result carries an echo byte");

endmodule

bind serial_commanded_rgb_pwm scrp_checker u_scrp_checker (.*);
